[rtl/core/diff_op_header_decoder_defines.svh]
// ----------------------------------------------------------------------------
// Diff operation header decoder assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef DIFF_OP_HEADER_DECODER_DEFINES_SVH
`define DIFF_OP_HEADER_DECODER_DEFINES_SVH

// same-cycle implication
`define DOHD_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DOHD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/dohd_pkg.sv]
// ----------------------------------------------------------------------------
// Diff operation header decoder package
// Widths, phase codes and the types passed between the decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dohd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned OpW   = 2;
  localparam int unsigned LenW  = 36;
  localparam int unsigned PosW  = 40;
  localparam int unsigned MaskW = 4;
  localparam int unsigned LeftW = 3;

  localparam logic [MaskW-1:0] MaskRst = 4'h3;

  localparam logic [1:0] PhaseHdr = 2'd0;
  localparam logic [1:0] PhaseLen = 2'd1;
  localparam logic [1:0] PhasePos = 2'd2;

  typedef struct packed {
    logic [OpW-1:0]  op_code;
    logic [LenW-1:0] length;
    logic [PosW-1:0] position;
    logic            has_position;
  } dohd_result_t;

  typedef struct packed {
    logic         valid;
    dohd_result_t result;
  } dohd_push_t;

endpackage

`default_nettype wire

[rtl/core/dohd_parser.sv]
// ----------------------------------------------------------------------------
// Diff operation header parser
// Walks header bytes through the first, length and position phases and
// produces one decoded result when a header completes.
// ----------------------------------------------------------------------------
`default_nettype none

module dohd_parser import dohd_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [MaskW-1:0] cfg_wdata_i,
  input  wire logic             accept_i,
  input  wire logic [ByteW-1:0] byte_i,
  output dohd_push_t            push_o
);

  logic [1:0]       phase_q, phase_d;
  logic [LeftW-1:0] left_q, left_d;
  logic [1:0]       size_q, size_d;
  logic [OpW-1:0]   op_q, op_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [MaskW-1:0] mask_q;
  logic             last;

  assign last = (left_q <= LeftW'(1));

  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    size_d  = size_q;
    op_d    = op_q;
    len_d   = len_q;
    pos_d   = pos_q;
    push_o  = '0;
    case (phase_q)
      PhaseLen: begin
        len_d  = {len_q[LenW-ByteW-1:0], byte_i};
        left_d = last ? '0 : left_q - LeftW'(1);
        if (last) begin
          if (mask_q[op_q]) begin
            phase_d = PhasePos;
            left_d  = {1'b0, size_q} + LeftW'(2);
            pos_d   = '0;
          end else begin
            phase_d                     = PhaseHdr;
            push_o.valid                = 1'b1;
            push_o.result.op_code       = op_q;
            push_o.result.length        = len_d;
            push_o.result.position      = '0;
            push_o.result.has_position  = 1'b0;
          end
        end
      end
      PhasePos: begin
        pos_d  = {pos_q[PosW-ByteW-1:0], byte_i};
        left_d = last ? '0 : left_q - LeftW'(1);
        if (last) begin
          phase_d                     = PhaseHdr;
          push_o.valid                = 1'b1;
          push_o.result.op_code       = op_q;
          push_o.result.length        = len_q;
          push_o.result.position      = pos_d;
          push_o.result.has_position  = 1'b1;
        end
      end
      default: begin
        size_d  = byte_i[7:6];
        op_d    = byte_i[5:4];
        len_d   = {{(LenW-4){1'b0}}, byte_i[3:0]};
        pos_d   = '0;
        left_d  = {1'b0, byte_i[7:6]} + LeftW'(1);
        phase_d = PhaseLen;
      end
    endcase
    if (!accept_i) begin
      push_o.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseHdr;
      left_q  <= '0;
      size_q  <= '0;
      op_q    <= '0;
      len_q   <= '0;
      pos_q   <= '0;
      mask_q  <= MaskRst;
    end else begin
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        phase_q <= phase_d;
        left_q  <= left_d;
        size_q  <= size_d;
        op_q    <= op_d;
        len_q   <= len_d;
        pos_q   <= pos_d;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/dohd_out_buf.sv]
// ----------------------------------------------------------------------------
// Diff operation header result buffer
// Two-entry output register that holds decoded results until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dohd_out_buf import dohd_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  dohd_push_t  push_i,
  output logic        ready_o,
  output logic        valid_o,
  input  wire logic   ready_i,
  output dohd_result_t result_o
);

  dohd_result_t slot0_q, slot1_q;
  logic [1:0]   cnt_q, cnt_d;
  logic         pop;

  assign valid_o  = (cnt_q != 2'd0);
  assign ready_o  = (cnt_q != 2'd2);
  assign result_o = slot0_q;
  assign pop      = valid_o & ready_i;
  assign cnt_d    = cnt_q + {1'b0, push_i.valid} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case ({pop, push_i.valid})
      2'b11: begin
        if (cnt_q == 2'd1) begin
          slot0_q <= push_i.result;
        end else begin
          slot0_q <= slot1_q;
          slot1_q <= push_i.result;
        end
      end
      2'b10: begin
        slot0_q <= slot1_q;
      end
      2'b01: begin
        if (cnt_q == 2'd0) begin
          slot0_q <= push_i.result;
        end else begin
          slot1_q <= push_i.result;
        end
      end
      default: begin
        slot0_q <= slot0_q;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/diff_op_header_decoder.sv]
// ----------------------------------------------------------------------------
// Diff operation header decoder
// Decodes a byte stream of variable-length diff operation headers into
// operation, length and position results.
// ----------------------------------------------------------------------------
// One header byte is taken per cycle while in_ready_o is high. A header is
// a first byte (size code in bits 7:6, operation in bits 5:4, top length
// bits in 3:0), then size+1 big-endian length bytes, then size+2 position
// bytes when the operation's bit is set in the position mask (sampled on
// the last length byte). Each result leaves through a registered
// two-entry output buffer; in_ready_o drops only while two results wait.
`default_nettype none

module diff_op_header_decoder import dohd_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [MaskW-1:0] cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ByteW-1:0] in_byte_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [OpW-1:0]        op_code_o,
  output logic [LenW-1:0]       length_o,
  output logic [PosW-1:0]       position_o,
  output logic                  has_position_o
);

  dohd_push_t   push;
  dohd_result_t result;
  logic         accept;

  assign accept = in_valid_i & in_ready_o;

  dohd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .byte_i      (in_byte_i),
    .push_o      (push)
  );

  dohd_out_buf u_out_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .ready_o  (in_ready_o),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .result_o (result)
  );

  assign op_code_o      = result.op_code;
  assign length_o       = result.length;
  assign position_o     = result.position;
  assign has_position_o = result.has_position;

endmodule

`default_nettype wire

[rtl/core/dohd_checker.sv]
// ----------------------------------------------------------------------------
// Diff operation header decoder checker
// Port-level assertions on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "diff_op_header_decoder_defines.svh"

module dohd_checker import dohd_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             cfg_we_i,
  input wire logic [MaskW-1:0] cfg_wdata_i,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic [ByteW-1:0] in_byte_i,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [OpW-1:0]   op_code_o,
  input wire logic [LenW-1:0]  length_o,
  input wire logic [PosW-1:0]  position_o,
  input wire logic             has_position_o
);

  logic unused_cfg;
  assign unused_cfg = cfg_we_i ^ (^cfg_wdata_i) ^ (^in_byte_i);

  `DOHD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(op_code_o) && $stable(length_o) && $stable(position_o) && $stable(has_position_o), "result changed while stalled")
  `DOHD_ASSERT_NOW(a_no_pos_zero, out_valid_o && !has_position_o, position_o == '0, "position set without position bytes")
  `DOHD_ASSERT_NEXT(a_no_spurious, !(in_valid_i && in_ready_o) && !out_valid_o, !out_valid_o, "result without a transaction")
  `DOHD_ASSERT_NEXT(a_full_holds, out_valid_o && !out_ready_i && !in_ready_o, !in_ready_o, "buffer drained without a transaction")

endmodule

bind diff_op_header_decoder dohd_checker u_dohd_checker (.*);

`default_nettype wire
